### rtl/record_interchange_sorter_defines.svh
// Assertion macros shared by the record interchange sorter RTL.
// Depends on nothing; expects a clock named clk and a reset named rst_n in scope.
`ifndef RECORD_INTERCHANGE_SORTER_DEFINES_SVH
`define RECORD_INTERCHANGE_SORTER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define RIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define RIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ris_pkg.sv
// Shared types and constants of the record interchange sorter.
// No dependencies.
`default_nettype none

package ris_pkg;

  localparam int MAX_RECORDS_DEF = 64;

  localparam int TAG_W   = 16;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int MEALS_W = 5;
  localparam int FEE_W   = 21;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 64;

  localparam logic [FEE_W-1:0] FEE_PER_MEAL = FEE_W'(50000);

  // One stored record, meals in the lowest bits.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [MEALS_W-1:0] meals;
  } rec_t;

  typedef struct packed {
    logic we;
    rec_t data;
  } wr_req_t;

  // Output register control from the sequencer.
  typedef struct packed {
    logic load;
    logic last;
  } emit_t;

endpackage

`default_nettype wire

### rtl/ris_store.sv
// Record store: one write port, one read port with registered read data.
// Depends on ris_pkg.
`default_nettype none

module ris_store
  import ris_pkg::*;
#(
  parameter int DEPTH = MAX_RECORDS_DEF
) (
  input  wire logic                     clk,
  input  wire wr_req_t                  wr,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output rec_t                          rdata
);

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/ris_ctrl.sv
// Sequencer: loads records, runs the interchange sort over the store, emits.
// Depends on ris_pkg and record_interchange_sorter_defines.svh.
`default_nettype none
`include "record_interchange_sorter_defines.svh"

module ris_ctrl
  import ris_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire rec_t                           in_rec,
  input  wire logic                           in_last,
  input  wire logic                           sort_by_fee,
  output wr_req_t                             mem_wr,
  output logic [$clog2(MAX_RECORDS)-1:0]      mem_waddr,
  output logic [$clog2(MAX_RECORDS)-1:0]      mem_raddr,
  input  wire rec_t                           mem_rdata,
  output emit_t                               emit,
  input  wire logic                           out_accept
);

  localparam int ADDR_W = $clog2(MAX_RECORDS);
  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int CMP_W  = ADDR_W + 1;

  typedef enum logic [7:0] {
    S_LOAD   = 8'b0000_0001,
    S_RDI    = 8'b0000_0010,
    S_LDI    = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_WB     = 8'b0001_0000,
    S_EMRD   = 8'b0010_0000,
    S_EMLD   = 8'b0100_0000,
    S_EMHOLD = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [ADDR_W-1:0] j_r, j_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  rec_t              cur_r, cur_nxt;

  logic [CMP_W-1:0]  n_ext, j_inc, i_inc, i_inc2, k_inc;
  logic              has_room;
  logic [CNT_W-1:0]  cnt_after;
  logic              swap;
  logic              last_out;

  assign n_ext     = CMP_W'(count_r);
  assign j_inc     = {1'b0, j_r} + CMP_W'(1);
  assign i_inc     = {1'b0, i_r} + CMP_W'(1);
  assign i_inc2    = {1'b0, i_r} + CMP_W'(2);
  assign k_inc     = {1'b0, k_r} + CMP_W'(1);
  assign has_room  = (count_r != CNT_W'(MAX_RECORDS));
  assign cnt_after = count_r + CNT_W'(has_room);
  assign last_out  = (k_inc == n_ext);

  // Fee is meals times a positive constant, so ordering by meals is the same.
  assign swap = sort_by_fee ? (cur_r.meals > mem_rdata.meals)
                            : (cur_r.month > mem_rdata.month);

  assign in_ready = (state_r == S_LOAD);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    cur_nxt     = cur_r;
    mem_wr.we   = 1'b0;
    mem_wr.data = in_rec;
    mem_waddr   = count_r[ADDR_W-1:0];
    mem_raddr   = i_r;
    emit.load   = 1'b0;
    emit.last   = last_out;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          mem_wr.we = has_room;
          count_nxt = cnt_after;
          if (in_last) begin
            i_nxt = '0;
            k_nxt = '0;
            state_nxt = (cnt_after > CNT_W'(1)) ? S_RDI : S_EMRD;
          end
        end
      end
      S_RDI: begin
        state_nxt = S_LDI;
      end
      S_LDI: begin
        cur_nxt   = mem_rdata;
        mem_raddr = i_inc[ADDR_W-1:0];
        j_nxt     = i_inc[ADDR_W-1:0];
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (swap) begin
          mem_wr.we   = 1'b1;
          mem_wr.data = cur_r;
          mem_waddr   = j_r;
          cur_nxt     = mem_rdata;
        end
        if (j_inc < n_ext) begin
          mem_raddr = j_inc[ADDR_W-1:0];
          j_nxt     = j_inc[ADDR_W-1:0];
        end else begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        mem_wr.we   = 1'b1;
        mem_wr.data = cur_r;
        mem_waddr   = i_r;
        if (i_inc2 < n_ext) begin
          mem_raddr = i_inc[ADDR_W-1:0];
          i_nxt     = i_inc[ADDR_W-1:0];
          state_nxt = S_LDI;
        end else begin
          k_nxt     = '0;
          state_nxt = S_EMRD;
        end
      end
      S_EMRD: begin
        mem_raddr = k_r;
        state_nxt = S_EMLD;
      end
      S_EMLD: begin
        emit.load = 1'b1;
        state_nxt = S_EMHOLD;
      end
      S_EMHOLD: begin
        mem_raddr = k_inc[ADDR_W-1:0];
        if (out_accept) begin
          if (last_out) begin
            count_nxt = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_inc[ADDR_W-1:0];
            state_nxt = S_EMLD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // A write during the sort never hits the entry being read in the same cycle while the sort goes on.
  `RIS_ASSERT_NOW(a_no_rw_clash,
    mem_wr.we && (state_r == S_SCAN || state_r == S_WB)
      && (state_nxt == S_SCAN || state_nxt == S_LDI),
    mem_waddr != mem_raddr, "store read and write collide during sort")

  `RIS_ASSERT_NOW(a_scan_order, state_r == S_SCAN, j_r > i_r,
    "scan index not above the held index")

  `RIS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_RECORDS),
    "record count beyond capacity")

  `RIS_ASSERT_NEXT(a_batch_end, state_r == S_EMHOLD && out_accept && last_out,
    count_r == '0 && in_ready, "batch did not restart after final record")

endmodule

`default_nettype wire

### rtl/record_interchange_sorter.sv
// Record interchange sorter top level: stream ports, sort key register, output register.
// Depends on ris_pkg, ris_store and ris_ctrl.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------------
//   in_     | slave     | in_tvalid/in_tready | tdata tag,month,year,meals; tlast=last
//   out_    | master    | out_tvalid/tready   | tdata tag,month,year,meals,fee; tlast
//   cfg_    | slave     | cfg_valid/cfg_ready | cfg_data = sort_by_fee
//
// Loading accepts one request per cycle while the store is collecting a batch.
// After the last request the input stalls: n > 1 records sort via the single read port
// (S_RDI, then per held record S_LDI, S_SCAN, S_WB); S_EMRD then addresses the first
// record, and each is emitted via S_EMLD, then S_EMHOLD plus any output back-pressure.
// Reset clears control state only; the store holds no valid bits and needs no clearing.
// Configuration is always ready and is meant to be written while the block is idle.
`default_nettype none

module record_interchange_sorter
  import ris_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [15:0] record_tag, [19:16] month, [33:20] year, [38:34] meal_count, [39] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [15:0] out_tag, [19:16] out_month, [33:20] out_year, [38:34] out_meals,
  // [59:39] out_fee, [63:60] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_data
);

  localparam int ADDR_W = $clog2(MAX_RECORDS);

  rec_t              in_rec;
  rec_t              mem_rdata;
  wr_req_t           mem_wr;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  emit_t             emit;
  logic              out_accept;

  logic              sort_by_fee_r;
  logic              out_valid_r;
  rec_t              out_rec_r;
  logic [FEE_W-1:0]  out_fee_r;
  logic              out_last_r;

  // Unpack the input request, first field in the lowest bits.
  assign in_rec.tag   = in_tdata[15:0];
  assign in_rec.month = in_tdata[19:16];
  assign in_rec.year  = in_tdata[33:20];
  assign in_rec.meals = in_tdata[38:34];

  assign cfg_ready  = 1'b1;
  assign out_accept = out_valid_r & out_tready;

  // Hold the sort key selection between batches.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_by_fee_r <= 1'b0;
    end else if (cfg_valid) begin
      sort_by_fee_r <= cfg_data;
    end
  end

  ris_store #(
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk   (clk),
    .wr    (mem_wr),
    .waddr (mem_waddr),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ris_ctrl #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_rec      (in_rec),
    .in_last     (in_tlast),
    .sort_by_fee (sort_by_fee_r),
    .mem_wr      (mem_wr),
    .mem_waddr   (mem_waddr),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .emit        (emit),
    .out_accept  (out_accept)
  );

  // Output register: load on the sequencer's strobe, drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_accept) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_rec_r  <= mem_rdata;
      out_fee_r  <= FEE_W'(mem_rdata.meals) * FEE_PER_MEAL;
      out_last_r <= emit.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, out_fee_r, out_rec_r.meals, out_rec_r.year,
                       out_rec_r.month, out_rec_r.tag};

endmodule

`default_nettype wire

### bench/tb_record_interchange_sorter.sv
`timescale 1ns / 100ps
// Self-checking bench for record_interchange_sorter: streams batches of meal records and
// predicts the interchange-sorted output. Every emitted request is checked field by field.
// Depends on ris_pkg and the RTL of record_interchange_sorter.

module tb_record_interchange_sorter;
  import ris_pkg::*;

  localparam int STORE_DEPTH      = MAX_RECORDS_DEF;
  localparam int RANDOM_ITEMS     = 135;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int MAX_PRINTED      = 60;
  localparam int PLAN_ROWS        = 22;

  // One record as the output channel should carry it.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [MEALS_W-1:0] meals;
    logic [FEE_W-1:0]   fee;
    logic               last;
  } sorted_rec_t;

  // Directed plan: plain records, single-record batches with a typed result,
  // floods of random records, and sort key changes.
  typedef enum logic [1:0] {ROW_RECORD, ROW_TYPED, ROW_FLOOD, ROW_SORT_KEY} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [TAG_W-1:0]   tag;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [MEALS_W-1:0] meals;
    logic               last;
    logic [FEE_W-1:0]   fee;
    logic [7:0]         count;
    logic               by_fee;
  } plan_row_t;

  plan_row_t plan [PLAN_ROWS] = '{
    // single records sorted by month: field extremes, months outside 1..12
    '{ROW_TYPED,  16'h0000, 4'd1,  14'd0,    5'd0,  1'b1, 21'd0,       8'd0,  1'b0},
    '{ROW_TYPED,  16'hFFFF, 4'd12, 14'd9999, 5'd31, 1'b1, 21'd1550000, 8'd0,  1'b0},
    '{ROW_TYPED,  16'h5555, 4'd0,  14'd5461, 5'd10, 1'b1, 21'd500000,  8'd0,  1'b0},
    '{ROW_TYPED,  16'hAAAA, 4'd15, 14'd8191, 5'd21, 1'b1, 21'd1050000, 8'd0,  1'b0},
    // five records by month, with a tie and both odd months
    '{ROW_RECORD, 16'h0101, 4'd9,  14'd2024, 5'd3,  1'b0, 21'd0,       8'd0,  1'b0},
    '{ROW_RECORD, 16'h0202, 4'd3,  14'd1999, 5'd30, 1'b0, 21'd0,       8'd0,  1'b0},
    '{ROW_RECORD, 16'h0303, 4'd3,  14'd1,    5'd7,  1'b0, 21'd0,       8'd0,  1'b0},
    '{ROW_RECORD, 16'h0404, 4'd13, 14'd9998, 5'd7,  1'b0, 21'd0,       8'd0,  1'b0},
    '{ROW_RECORD, 16'h0505, 4'd0,  14'd100,  5'd0,  1'b1, 21'd0,       8'd0,  1'b0},
    '{ROW_SORT_KEY, 16'h0, 4'd0,   14'd0,    5'd0,  1'b0, 21'd0,       8'd0,  1'b1},
    '{ROW_TYPED,  16'h1234, 4'd6,  14'd2000, 5'd31, 1'b1, 21'd1550000, 8'd0,  1'b0},
    // five records by fee, with a tie
    '{ROW_RECORD, 16'h1111, 4'd1,  14'd10,   5'd31, 1'b0, 21'd0,       8'd0,  1'b0},
    '{ROW_RECORD, 16'h2222, 4'd2,  14'd20,   5'd0,  1'b0, 21'd0,       8'd0,  1'b0},
    '{ROW_RECORD, 16'h3333, 4'd3,  14'd30,   5'd16, 1'b0, 21'd0,       8'd0,  1'b0},
    '{ROW_RECORD, 16'h4444, 4'd4,  14'd40,   5'd16, 1'b0, 21'd0,       8'd0,  1'b0},
    '{ROW_RECORD, 16'h5555, 4'd5,  14'd50,   5'd1,  1'b1, 21'd0,       8'd0,  1'b0},
    // fill the store, then a last request that is dropped but still sorts
    '{ROW_FLOOD,  16'h0,    4'd0,  14'd0,    5'd0,  1'b0, 21'd0,       8'd64, 1'b0},
    '{ROW_RECORD, 16'h6666, 4'd8,  14'd4321, 5'd2,  1'b1, 21'd0,       8'd0,  1'b0},
    '{ROW_SORT_KEY, 16'h0, 4'd0,   14'd0,    5'd0,  1'b0, 21'd0,       8'd0,  1'b0},
    // exactly full: the last request takes the final slot
    '{ROW_FLOOD,  16'h0,    4'd0,  14'd0,    5'd0,  1'b0, 21'd0,       8'd63, 1'b0},
    '{ROW_RECORD, 16'h6767, 4'd11, 14'd77,   5'd12, 1'b1, 21'd0,       8'd0,  1'b0},
    // a fresh batch must start empty after a full one
    '{ROW_TYPED,  16'h7777, 4'd7,  14'd7,    5'd7,  1'b1, 21'd350000,  8'd0,  1'b0}
  };

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_data   = 1'b0;

  // Predictor state: its own copy of the store, the fill level and the sort key.
  rec_t          meal_store [STORE_DEPTH];
  int unsigned   store_fill = 0;
  logic          fee_order  = 1'b0;
  sorted_rec_t   sorted_queue [$];
  int unsigned   mismatches = 0;

  // Idling control shared by the sender and the receiver.
  bit gaps_on       = 1'b1;
  bit long_hold_req = 1'b0;

  record_interchange_sorter #(.MAX_RECORDS(STORE_DEPTH)) u_top (.*);

  always #6 clk = ~clk;

  // Fee never exceeds 31 * 50000, so it fits the fee width.
  function automatic logic [FEE_W-1:0] fee_of(logic [MEALS_W-1:0] meals);
    return FEE_W'(meals * FEE_PER_MEAL);
  endfunction

  function automatic logic [FEE_W-1:0] sort_key(rec_t r);
    return fee_order ? fee_of(r.meals) : FEE_W'(r.month);
  endfunction

  // Store one accepted request; on the last one, run the interchange sort over the
  // batch and queue the sorted records, unless the caller has typed them in itself.
  function automatic void take_record(rec_t r, logic last, bit publish);
    rec_t        held;
    int unsigned n;
    sorted_rec_t res;
    if (store_fill < STORE_DEPTH) begin
      meal_store[store_fill] = r;
      store_fill++;
    end
    if (!last) return;
    n = store_fill;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (sort_key(meal_store[i]) > sort_key(meal_store[j])) begin
          held = meal_store[i];
          meal_store[i] = meal_store[j];
          meal_store[j] = held;
        end
      end
    end
    if (publish) begin
      for (int i = 0; i < n; i++) begin
        res.tag   = meal_store[i].tag;
        res.month = meal_store[i].month;
        res.year  = meal_store[i].year;
        res.meals = meal_store[i].meals;
        res.fee   = fee_of(meal_store[i].meals);
        res.last  = (i + 1 == n);
        sorted_queue.push_back(res);
      end
    end
    store_fill = 0;
  endfunction

  // Narrow batches draw keys from two values each, so ties are frequent.
  function automatic rec_t random_record(bit narrow);
    rec_t r;
    r.tag = TAG_W'($urandom);
    if (narrow) r.month = $urandom_range(0, 1) ? 4'd3 : 4'd7;
    else if ($urandom_range(0, 9) == 0) r.month = MONTH_W'($urandom_range(0, 15));
    else r.month = MONTH_W'($urandom_range(1, 12));
    r.year = YEAR_W'($urandom_range(0, 9999));
    if (narrow) r.meals = $urandom_range(0, 1) ? 5'd5 : 5'd9;
    else r.meals = MEALS_W'($urandom_range(0, 31));
    return r;
  endfunction

  task automatic report(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Offer one request and return at the edge that accepts it. Valid stays high
  // afterwards so back-to-back requests need no second assignment in one step.
  task automatic send_record(rec_t r, logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, r.meals, r.year, r.month, r.tag};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and hold until every queued record has come back, then let the
  // block settle into its loading state.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sorted_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_sort_key(logic by_fee);
    cfg_valid <= 1'b1;
    cfg_data  <= by_fee;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fee_order = by_fee;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request so the block
  // backs up and stalls its input while the sender keeps offering.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Compare every accepted output request with the oldest expectation.
  always @(posedge clk) begin
    sorted_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (sorted_queue.size() == 0) begin
        report("unexpected result, tag", 0, out_tdata[15:0]);
      end else begin
        want = sorted_queue.pop_front();
        if (out_tdata[15:0] !== want.tag)   report("tag", want.tag, out_tdata[15:0]);
        if (out_tdata[19:16] !== want.month) report("month", want.month, out_tdata[19:16]);
        if (out_tdata[33:20] !== want.year) report("year", want.year, out_tdata[33:20]);
        if (out_tdata[38:34] !== want.meals) report("meals", want.meals, out_tdata[38:34]);
        if (out_tdata[59:39] !== want.fee)  report("fee", want.fee, out_tdata[59:39]);
        if (out_tlast !== want.last)        report("tlast", want.last, out_tlast);
      end
    end
  end

  initial begin : stimulus
    rec_t        r;
    int unsigned sent;
    int unsigned batch_no;
    int unsigned batch_len;
    bit          narrow;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan.
    for (int k = 0; k < PLAN_ROWS; k++) begin
      r = '{plan[k].tag, plan[k].month, plan[k].year, plan[k].meals};
      case (plan[k].kind)
        ROW_SORT_KEY: begin
          wait_drained();
          write_sort_key(plan[k].by_fee);
        end
        ROW_FLOOD: begin
          repeat (plan[k].count) begin
            r = random_record(1'b0);
            send_record(r, 1'b0);
            take_record(r, 1'b0, 1'b1);
          end
        end
        ROW_TYPED: begin
          send_record(r, 1'b1);
          take_record(r, 1'b1, 1'b0);
          sorted_queue.push_back('{r.tag, r.month, r.year, r.meals, plan[k].fee, 1'b1});
        end
        default: begin
          send_record(r, plan[k].last);
          take_record(r, plan[k].last, 1'b1);
        end
      endcase
    end

    // Random batches: mostly short, one overflowing the store, the sort key
    // rewritten every few batches once the block has drained.
    sent = 0;
    batch_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if (batch_no % 5 == 0) begin
        wait_drained();
        write_sort_key(1'($urandom_range(0, 1)));
      end
      if (batch_no == 2) long_hold_req = 1'b1;
      if (sent > RANDOM_ITEMS * 4 / 5) gaps_on = 1'b0;
      if (batch_no == 4) batch_len = STORE_DEPTH + 3;
      else if ($urandom_range(0, 4) == 0) batch_len = $urandom_range(7, 16);
      else batch_len = $urandom_range(1, 6);
      narrow = $urandom_range(0, 2) == 0;
      for (int k = 0; k < batch_len; k++) begin
        r = random_record(narrow);
        send_record(r, k == batch_len - 1);
        take_record(r, k == batch_len - 1, 1'b1);
        sent++;
      end
      batch_no++;
    end

    // Let the last results drain, then a short settle.
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Far beyond the slowest correct run: 10 ms at a 12 ns clock.
  initial begin : watchdog
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ris_pkg.sv
rtl/ris_store.sv
rtl/ris_ctrl.sv
rtl/record_interchange_sorter.sv
bench/tb_record_interchange_sorter.sv
